### src/cfa_pkg.sv
// Shared types, constants and helper functions for the calendar field adjuster.
package cfa_pkg;

	// Field selector of one adjustment beat
	typedef enum logic [2:0] {
		CMD_YEAR   = 3'd0,
		CMD_MONTH  = 3'd1,
		CMD_DAY    = 3'd2,
		CMD_HOUR   = 3'd3,
		CMD_MINUTE = 3'd4
	} cmd_t;

	// Configuration register indexes
	localparam logic REG_YEAR_LOW  = 1'b0;
	localparam logic REG_YEAR_HIGH = 1'b1;

	// Reset values of the year limits
	localparam logic [11:0] YEAR_LOW_RST  = 12'd2000;
	localparam logic [11:0] YEAR_HIGH_RST = 12'd2099;

	// Wrap moduli
	localparam logic [7:0] MONTHS_PER_YEAR = 8'd12;
	localparam logic [7:0] HOURS_PER_DAY   = 8'd24;
	localparam logic [7:0] MINS_PER_HOUR   = 8'd60;

	// One input beat
	typedef struct packed {
		logic [2:0]        command;
		logic signed [5:0] step;
		logic [11:0]       year;
		logic [3:0]        month;
		logic [4:0]        day;
		logic [4:0]        hour;
		logic [5:0]        minute;
		logic [5:0]        second;
	} item_t;

	// One result beat
	typedef struct packed {
		logic [11:0] year;
		logic [3:0]  month;
		logic [4:0]  day;
		logic [4:0]  hour;
		logic [5:0]  minute;
		logic [5:0]  second;
	} res_t;

	// Days in a month; a month code outside 1..12 counts as 31 days
	function automatic logic [4:0] month_len(input logic leap, input logic [3:0] m);
		logic [4:0] len;
		case (m)
			4'd2:                         len = leap ? 5'd29 : 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11:      len = 5'd30;
			default:                      len = 5'd31;
		endcase
		return len;
	endfunction

	// Reduce a non-negative value below 8*n into 0..n-1 by three compare-subtract folds
	function automatic logic [7:0] mod_fold(input logic [7:0] v, input logic [7:0] n);
		logic [7:0] r;
		logic [9:0] lim;
		r = v;
		for (int k = 2; k >= 0; k--) begin
			lim = {2'b00, n} << k;
			if ({2'b00, r} >= lim) begin
				r = r - lim[7:0];
			end
		end
		return r;
	endfunction

endpackage

### src/cfa_leap.sv
// Gregorian leap-year test on a 12-bit year.
module cfa_leap (
	input  logic [11:0] year,
	output logic        leap
);
	import cfa_pkg::*;

	logic [9:0]  quarter;
	logic [20:0] prod;
	logic [5:0]  quot;
	logic [9:0]  quot25;
	logic        div25;
	logic        div4;
	logic        div100;
	logic        div400;

	// Split off the factor four, then test year/4 for a multiple of 25 by reciprocal
	assign quarter = year[11:2];
	assign prod    = 21'(quarter) * 21'd1311;
	assign quot    = prod[20:15];
	assign quot25  = 10'(quot) * 10'd25;
	assign div25   = (quarter == quot25);

	// Combine the divisibility flags
	assign div4   = (year[1:0] == 2'b00);
	assign div100 = div4 && div25;
	assign div400 = (year[3:0] == 4'd0) && div25;
	assign leap   = (div4 && !div100) || div400;

endmodule

### src/cfa_adjust.sv
// Combinational step, wrap and day clamp of one date and time beat.
module cfa_adjust (
	input  cfa_pkg::item_t item,
	input  logic [11:0]    year_low,
	input  logic [11:0]    year_high,
	output cfa_pkg::res_t  res
);
	import cfa_pkg::*;

	logic [7:0]         step8;
	logic signed [13:0] year_step;
	logic               below;
	logic               above;
	logic               leap_cur;
	logic               leap_step;
	logic               leap_low;
	logic               leap_high;
	logic [11:0]        year_new;
	logic               leap_new;
	logic [4:0]         len_cur;
	logic [4:0]         len_year;
	logic [7:0]         month_idx;
	logic [3:0]         month_new;
	logic [4:0]         len_month;
	logic [7:0]         day_idx;
	logic [4:0]         day_new;
	logic [7:0]         hour_idx;
	logic [7:0]         min_idx;

	assign step8 = {{2{item.step[5]}}, item.step};

	// Leap flags for every year that can end up in the result
	cfa_leap u_leap_cur  (.year(item.year),       .leap(leap_cur));
	cfa_leap u_leap_step (.year(year_step[11:0]), .leap(leap_step));
	cfa_leap u_leap_low  (.year(year_low),        .leap(leap_low));
	cfa_leap u_leap_high (.year(year_high),       .leap(leap_high));

	// Year step: below the low limit wraps high, above the high limit wraps low
	assign year_step = $signed({2'b00, item.year}) + $signed({{8{item.step[5]}}, item.step});
	assign below     = year_step < $signed({2'b00, year_low});
	assign above     = year_step > $signed({2'b00, year_high});

	always_comb begin
		if (below) begin
			year_new = year_high;
			leap_new = leap_high;
		end else if (above) begin
			year_new = year_low;
			leap_new = leap_low;
		end else begin
			year_new = year_step[11:0];
			leap_new = leap_step;
		end
	end

	assign len_year = month_len(leap_new, item.month);

	// Month step: offset by three years of months to stay non-negative
	assign month_idx = {4'd0, item.month} + step8 + 8'd35;
	assign month_new = 4'(mod_fold(month_idx, MONTHS_PER_YEAR)) + 4'd1;
	assign len_month = month_len(leap_cur, month_new);

	// Day step: wrap within the current month, offset by two month lengths
	assign len_cur = month_len(leap_cur, item.month);
	assign day_idx = {3'd0, item.day} + step8 + {2'b00, len_cur, 1'b0} - 8'd1;
	assign day_new = 5'(mod_fold(day_idx, {3'd0, len_cur})) + 5'd1;

	// Hour and minute steps, offset by two days of hours and one hour of minutes
	assign hour_idx = {3'd0, item.hour} + step8 + 8'd48;
	assign min_idx  = {2'd0, item.minute} + step8 + 8'd60;

	// Step one field, keep the rest; year/month clamp day, minute zeros seconds
	always_comb begin
		res.year   = item.year;
		res.month  = item.month;
		res.day    = item.day;
		res.hour   = item.hour;
		res.minute = item.minute;
		res.second = item.second;
		case (cmd_t'(item.command))
			CMD_YEAR: begin
				res.year = year_new;
				res.day  = (item.day > len_year) ? len_year : item.day;
			end
			CMD_MONTH: begin
				res.month = month_new;
				res.day   = (item.day > len_month) ? len_month : item.day;
			end
			CMD_DAY: begin
				res.day = day_new;
			end
			CMD_HOUR: begin
				res.hour = 5'(mod_fold(hour_idx, HOURS_PER_DAY));
			end
			CMD_MINUTE: begin
				res.minute = 6'(mod_fold(min_idx, MINS_PER_HOUR));
				res.second = 6'd0;
			end
			default: begin
				res.year = item.year;
			end
		endcase
	end

endmodule

### src/calendar_field_adjust.sv
// Top level of the calendar field adjuster: input register, adjust logic, result register.
//
//  channel   handshake              payload
//  -------   ---------------------  -----------------------------------------------
//  command   start && !busy         command, step, year_in .. second_in
//  result    done (one-cycle beat)  year_out .. second_out
//  config    wr_en                  wr_index, wr_data
//
// One beat is taken every cycle; busy stays low.
// A command beat passes through the input register and then the adjust logic
// ahead of the result register, which holds its result beat.
// Reset clears the valid flags and loads the year limits with 2000 and 2099.
// The receiver cannot stall; each result is shown for exactly one cycle.
module calendar_field_adjust (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  command,
	input  logic [5:0]  step,
	input  logic [11:0] year_in,
	input  logic [3:0]  month_in,
	input  logic [4:0]  day_in,
	input  logic [4:0]  hour_in,
	input  logic [5:0]  minute_in,
	input  logic [5:0]  second_in,
	input  logic        wr_en,
	input  logic        wr_index,
	input  logic [11:0] wr_data,
	output logic        done,
	output logic [11:0] year_out,
	output logic [3:0]  month_out,
	output logic [4:0]  day_out,
	output logic [4:0]  hour_out,
	output logic [5:0]  minute_out,
	output logic [5:0]  second_out
);
	import cfa_pkg::*;

	logic [11:0] year_low_q;
	logic [11:0] year_high_q;
	logic        valid_s1;
	item_t       item_s1;
	res_t        res_comb;
	res_t        res_q;
	logic        done_q;

	assign busy = 1'b0;

	// Hold the year limits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			year_low_q  <= YEAR_LOW_RST;
			year_high_q <= YEAR_HIGH_RST;
		end else if (wr_en) begin
			if (wr_index == REG_YEAR_LOW) begin
				year_low_q <= wr_data;
			end else begin
				year_high_q <= wr_data;
			end
		end
	end

	// Capture the command beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			item_s1 <= '{command: command, step: step, year: year_in, month: month_in,
				day: day_in, hour: hour_in, minute: minute_in, second: second_in};
		end
	end

	cfa_adjust u_adjust (
		.item      (item_s1),
		.year_low  (year_low_q),
		.year_high (year_high_q),
		.res       (res_comb)
	);

	// Register the result beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			res_q <= res_comb;
		end
	end

	assign done       = done_q;
	assign year_out   = res_q.year;
	assign month_out  = res_q.month;
	assign day_out    = res_q.day;
	assign hour_out   = res_q.hour;
	assign minute_out = res_q.minute;
	assign second_out = res_q.second;

endmodule

### src/cfa_checker.sv
// Port-level checks for the calendar field adjuster, bound to the top level.
module cfa_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic [2:0]  command,
	input logic        done,
	input logic [3:0]  month_out,
	input logic [4:0]  day_out,
	input logic [4:0]  hour_out,
	input logic [5:0]  minute_out,
	input logic [5:0]  second_out
);
	import cfa_pkg::*;

	// Every command beat yields a result beat
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##2 done)
		else $error("command beat without result beat");

	// No result beat without a command beat behind it
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 2))
		else $error("result beat without command beat");

	// Hour step lands inside the day
	a_hour_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		(done && $past(command, 2) == CMD_HOUR) |-> hour_out < 5'd24)
		else $error("hour out of range after hour step");

	// Minute step wraps and clears the seconds
	a_minute_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		(done && $past(command, 2) == CMD_MINUTE) |-> (minute_out < 6'd60 && second_out == 6'd0))
		else $error("minute step result malformed");

	// Month step gives a month in 1..12 and a day of at most 31
	a_month_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		(done && $past(command, 2) == CMD_MONTH) |->
			(month_out >= 4'd1 && month_out <= 4'd12 && day_out <= 5'd31))
		else $error("month step result malformed");

endmodule

bind calendar_field_adjust cfa_checker u_cfa_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.start      (start),
	.busy       (busy),
	.command    (command),
	.done       (done),
	.month_out  (month_out),
	.day_out    (day_out),
	.hour_out   (hour_out),
	.minute_out (minute_out),
	.second_out (second_out)
);
